// File: rtl/core/chlex_pkg.sv
// shared types, token codes and keyword table for the character lexer
`default_nettype none

package chlex_pkg;

   localparam int KW_TABLE = 12;
   localparam logic [7:0] LEN_MAX = 8'd255;

   localparam logic [2:0] CAT_KEYWORD    = 3'd0;
   localparam logic [2:0] CAT_IDENTIFIER = 3'd1;
   localparam logic [2:0] CAT_INTEGER    = 3'd2;
   localparam logic [2:0] CAT_OPERATOR   = 3'd3;
   localparam logic [2:0] CAT_SPECIAL    = 3'd4;
   localparam logic [2:0] CAT_DELIMITER  = 3'd5;
   localparam logic [2:0] CAT_INVALID    = 3'd6;

   typedef struct packed {
      logic       letter;
      logic       digit;
      logic [2:0] single_cat;
   } class_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } kw_hit_type;

   typedef struct packed {
      logic [2:0]  category;
      logic [3:0]  keyword_index;
      logic [15:0] start_position;
      logic [7:0]  token_length;
      logic [7:0]  symbol;
      logic        last;
   } result_type;

   // keyword text, left-justified in six bytes
   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] off);
      logic [47:0] row;
      logic [47:0] shifted;
      case (k)
         4'd0:    row = {"if", 32'h0};
         4'd1:    row = {"else", 16'h0};
         4'd2:    row = {"while", 8'h0};
         4'd3:    row = {"for", 24'h0};
         4'd4:    row = {"int", 24'h0};
         4'd5:    row = "double";
         4'd6:    row = {"float", 8'h0};
         4'd7:    row = "printf";
         4'd8:    row = {"long", 16'h0};
         4'd9:    row = {"short", 8'h0};
         4'd10:   row = {"void", 16'h0};
         4'd11:   row = {"char", 16'h0};
         default: row = '0;
      endcase
      shifted = row << {off, 3'b000};
      return shifted[47:40];
   endfunction

   function automatic logic [2:0] kw_len(input logic [3:0] k);
      logic [2:0] len;
      case (k)
         4'd0:    len = 3'd2;
         4'd1:    len = 3'd4;
         4'd2:    len = 3'd5;
         4'd3:    len = 3'd3;
         4'd4:    len = 3'd3;
         4'd5:    len = 3'd6;
         4'd6:    len = 3'd5;
         4'd7:    len = 3'd6;
         4'd8:    len = 3'd4;
         4'd9:    len = 3'd5;
         4'd10:   len = 3'd4;
         4'd11:   len = 3'd4;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/chlex_class.sv
// character classifier: letter, digit and single-character token category
`default_nettype none

module chlex_class (
   input  wire logic [7:0]          chr,
   output chlex_pkg::class_type     cls
);
   import chlex_pkg::*;

   always_comb begin
      cls.letter = (chr >= "A" && chr <= "Z") || (chr >= "a" && chr <= "z") || chr == "_";
      cls.digit  = (chr >= "0" && chr <= "9");
      priority if (chr == "+" || chr == "-" || chr == "*" || chr == "/") begin
         cls.single_cat = CAT_OPERATOR;
      end else if (chr == "!" || chr == "@" || chr == "#" || chr == "$" || chr == "%" ||
                   chr == "^" || chr == "=") begin
         cls.single_cat = CAT_SPECIAL;
      end else if (chr == 8'd32 || (chr >= 8'd9 && chr <= 8'd13)) begin
         cls.single_cat = CAT_DELIMITER;
      end else begin
         cls.single_cat = CAT_INVALID;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/chlex_kw.sv
// keyword candidate update and keyword match at run close
`default_nettype none

module chlex_kw #(
   parameter int KW_USED = 12
) (
   input  wire logic [KW_USED-1:0] add_cand,
   input  wire logic [7:0]         add_len,
   input  wire logic [7:0]         chr,
   output logic [KW_USED-1:0]      next_cand,
   output logic [7:0]              next_len,
   input  wire logic [KW_USED-1:0] close_cand,
   input  wire logic [7:0]         close_len,
   output chlex_pkg::kw_hit_type   close_hit
);
   import chlex_pkg::*;

   always_comb begin
      if (add_len >= LEN_MAX) begin
         next_len  = LEN_MAX;
         next_cand = '0;
      end else begin
         next_len = add_len + 8'd1;
         for (int k = 0; k < KW_USED; k++) begin
            next_cand[k] = add_cand[k] && (add_len < {5'b0, kw_len(4'(k))}) &&
                           (kw_char(4'(k), add_len[2:0]) == chr);
         end
      end
   end

   always_comb begin
      close_hit = '0;
      if (close_len < LEN_MAX) begin
         for (int k = KW_USED - 1; k >= 0; k--) begin
            if (close_cand[k] && close_len == {5'b0, kw_len(4'(k))}) begin
               close_hit.hit   = 1'b1;
               close_hit.index = 4'(k);
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/character_lexer_with_keywords.sv
// character lexer with keyword recognition, top level
// a request is held in the input register until the result register can load its tokens
// throughput: one request per cycle while rsp_tready is high; a request that ends
//    a run with a single-character token holds the next while its second token is pending
// reset: synchronous, active high; clears the open run, position and both channels
`default_nettype none

module character_lexer_with_keywords #(
   parameter int KEYWORD_COUNT  = 12,
   parameter int POSITION_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // character[7:0]
   input  wire logic [0:0]  req_tuser,   // action[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // keyword_index[3:0], start_position[19:4],
                                         // token_length[27:20], symbol[35:28], zero[39:36]
   output logic [2:0]       rsp_tuser,   // category[2:0]
   output logic             rsp_tlast
);
   import chlex_pkg::*;

   localparam int KW_USED = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;
   localparam logic [KW_USED-1:0] CAND_ALL = {KW_USED{1'b1}};

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_WORD = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;

   logic                      in_valid_ff, in_valid_in;
   logic                      in_act_ff;
   logic [7:0]                in_chr_ff;

   logic [1:0]                mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] start_ff, start_in;
   logic [7:0]                len_ff, len_in;
   logic [KW_USED-1:0]        cand_ff, cand_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;

   result_type                out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;
   result_type                pend_ff, pend_in;
   logic                      pend_valid_ff, pend_valid_in;

   class_type                 cls;
   kw_hit_type                hit;
   logic [KW_USED-1:0]        add_cand, next_cand;
   logic [7:0]                add_len, next_len;
   logic                      extend, open_run;
   logic                      can_load, fire;
   result_type                close_tok, single_tok, r0, r1;
   logic [1:0]                n;
   logic [POSITION_WIDTH+15:0] start_pad, pos_pad;

   chlex_class u_class (
      .chr (in_chr_ff),
      .cls (cls)
   );

   chlex_kw #(.KW_USED(KW_USED)) u_kw (
      .add_cand   (add_cand),
      .add_len    (add_len),
      .chr        (in_chr_ff),
      .next_cand  (next_cand),
      .next_len   (next_len),
      .close_cand (cand_ff),
      .close_len  (len_ff),
      .close_hit  (hit)
   );

   assign extend   = (mode_ff == MODE_WORD && (cls.letter || cls.digit)) ||
                     (mode_ff == MODE_NUM && cls.digit);
   assign open_run = !extend;
   assign add_cand = open_run ? CAND_ALL : cand_ff;
   assign add_len  = open_run ? 8'd0 : len_ff;

   assign start_pad = {16'b0, start_ff};
   assign pos_pad   = {16'b0, pos_ff};

   always_comb begin
      close_tok = '0;
      close_tok.start_position = start_pad[15:0];
      close_tok.token_length   = len_ff;
      if (mode_ff == MODE_WORD && hit.hit) begin
         close_tok.category      = CAT_KEYWORD;
         close_tok.keyword_index = hit.index;
      end else if (mode_ff == MODE_WORD) begin
         close_tok.category = CAT_IDENTIFIER;
      end else begin
         close_tok.category = CAT_INTEGER;
      end
      single_tok = '0;
      single_tok.category       = cls.single_cat;
      single_tok.start_position = pos_pad[15:0];
      single_tok.token_length   = 8'd1;
      single_tok.symbol         = in_chr_ff;
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      cand_in  = cand_ff;
      pos_in   = pos_ff;
      r0 = '0;
      r1 = '0;
      n  = 2'd0;
      if (in_act_ff) begin
         if (mode_ff != MODE_IDLE) begin
            r0       = close_tok;
            n        = 2'd1;
            mode_in  = MODE_IDLE;
            start_in = '0;
            len_in   = '0;
            cand_in  = CAND_ALL;
         end
      end else begin
         if (extend) begin
            len_in  = next_len;
            cand_in = next_cand;
         end else begin
            if (mode_ff != MODE_IDLE) begin
               r0 = close_tok;
               n  = 2'd1;
            end
            priority if (cls.letter || cls.digit) begin
               mode_in  = cls.letter ? MODE_WORD : MODE_NUM;
               start_in = pos_ff;
               len_in   = next_len;
               cand_in  = next_cand;
            end else begin
               if (n == 2'd0) begin
                  r0 = single_tok;
               end else begin
                  r1 = single_tok;
               end
               n        = n + 2'd1;
               mode_in  = MODE_IDLE;
               start_in = '0;
               len_in   = '0;
               cand_in  = CAND_ALL;
            end
         end
         pos_in = pos_ff + 1'b1;
      end
      r0.last = (n == 2'd1);
      r1.last = 1'b1;
   end

   assign can_load   = !out_valid_ff || (rsp_tready && !pend_valid_ff);
   assign fire       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (fire) begin
         out_in        = r0;
         out_valid_in  = (n != 2'd0);
         pend_in       = r1;
         pend_valid_in = (n == 2'd2);
      end else if (out_valid_ff && rsp_tready) begin
         out_in        = pend_ff;
         out_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         mode_ff       <= MODE_IDLE;
         start_ff      <= '0;
         len_ff        <= '0;
         cand_ff       <= CAND_ALL;
         pos_ff        <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (fire) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
            len_ff   <= len_in;
            cand_ff  <= cand_in;
            pos_ff   <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_act_ff <= req_tuser[0];
         in_chr_ff <= req_tdata;
      end
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.category;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {4'b0, out_ff.symbol, out_ff.token_length,
                        out_ff.start_position, out_ff.keyword_index};

   // a first token of two is always followed by the second
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |=> rsp_tvalid)
      else $error("second token of a request lost");

   a_pend_needs_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("pending token without a head token");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) == (len_ff == 8'd0))
      else $error("run length disagrees with run mode");

   a_idle_cand: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> cand_ff == CAND_ALL)
      else $error("keyword candidates not restored while idle");

endmodule

`default_nettype wire
